@@ hw/rtl/pdw_pkg.sv @@
// shared types and constants for the pwm divider, wrap and level calculator
`timescale 1ns / 1ps

package pdw_pkg;

  localparam int unsigned DIV_STAGES = 32;

  localparam logic [27:0] CLOCK_RESET = 28'd125000000;
  localparam logic [11:0] DIV16_MIN   = 12'd16;
  localparam logic [11:0] DIV16_MAX   = 12'd4095;
  localparam logic [15:0] WRAP_MAX    = 16'd65535;
  // ceil(2^28 / 45), level over 360 as (product >> 3) * recip >> 28
  localparam logic [22:0] LEVEL_RECIP = 23'd5965233;

  typedef struct packed {
    logic        vld;
    logic [19:0] freq;
    logic [8:0]  duty;
    logic [11:0] div16;
    logic        err;
    logic [15:0] wrap;
  } pdw_sb_t;

endpackage

@@ hw/rtl/pwm_divider_wrap_level_calc.sv @@
// top level: pwm clock divider, counter wrap and compare level calculator
`timescale 1ns / 1ps

// One word is taken every cycle unless in_stall; each gives one result, and
// the pipeline is three chained 32-stage restoring dividers (divider,
// clock over divider, over frequency) plus input, clamp, wrap, multiply,
// reciprocal multiply (level over 360) and output registers. The whole
// pipeline holds while a result waits under out_stall. cfg_data sets the
// source clock in hertz and may be written only while the pipeline is empty.

module pwm_divider_wrap_level_calc
  import pdw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [27:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [19:0] in_freq_hz,
  input  logic [8:0]  in_duty_deg,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_div_int,
  output logic [3:0]  out_div_frac,
  output logic [15:0] out_wrap_value,
  output logic [15:0] out_compare_level,
  output logic        out_range_error
);

  logic [27:0] clk_hz_r;
  logic        en;
  logic [28:0] clk_sum;
  logic [16:0] c1;

  pdw_sb_t     sb0_r, sb1_r, sb2_r, sb3_r, sb4_r;
  pdw_sb_t     sb_a, sb_b, sb_c;
  pdw_sb_t     sb1_nxt, sb2_nxt;
  logic [31:0] num0_r;
  logic [31:0] qa, qb, qc;
  logic [24:0] prod_r;
  logic [44:0] rec_r;
  logic [16:0] lvl_q;
  logic [31:0] qc_m1;

  logic        out_valid_r;
  logic [11:0] out_div16_r;
  logic [15:0] out_wrap_r;
  logic [15:0] out_level_r;
  logic        out_err_r;

  assign cfg_ready = 1'b1;
  assign en        = !(out_valid_r && out_stall);
  assign in_stall  = out_valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_hz_r <= CLOCK_RESET;
    end else if (cfg_valid) begin
      clk_hz_r <= cfg_data;
    end
  end

  assign clk_sum = {1'b0, clk_hz_r} + 29'd4095;
  assign c1      = clk_sum[28:12];

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb0_r  <= '0;
      num0_r <= '0;
    end else if (en) begin
      sb0_r  <= '{vld: in_valid, freq: in_freq_hz, duty: in_duty_deg,
                  div16: 12'd0, err: 1'b0, wrap: 16'd0};
      num0_r <= 32'(c1) + 32'(in_freq_hz) - 32'd1;
    end
  end

  pdw_div u_div_a (.clk, .en, .num(num0_r), .den(sb0_r.freq), .quo(qa));
  pdw_dly u_dly_a (.clk, .rst_n, .en, .din(sb0_r), .dout(sb_a));

  // divider clamp and range error flag
  always_comb begin
    sb1_nxt = sb_a;
    if (qa < 32'(DIV16_MIN)) begin
      sb1_nxt.div16 = DIV16_MIN;
    end else if (qa > 32'(DIV16_MAX)) begin
      sb1_nxt.div16 = DIV16_MAX;
      sb1_nxt.err   = 1'b1;
    end else begin
      sb1_nxt.div16 = qa[11:0];
    end
    if ({8'd0, sb_a.freq} > clk_hz_r) sb1_nxt.err = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb1_r <= '0;
    end else if (en) begin
      sb1_r <= sb1_nxt;
    end
  end

  pdw_div u_div_b (.clk, .en, .num({clk_hz_r, 4'd0}), .den({8'd0, sb1_r.div16}),
                   .quo(qb));
  pdw_dly u_dly_b (.clk, .rst_n, .en, .din(sb1_r), .dout(sb_b));

  pdw_div u_div_c (.clk, .en, .num(qb), .den(sb_b.freq), .quo(qc));
  pdw_dly u_dly_c (.clk, .rst_n, .en, .din(sb_b), .dout(sb_c));

  // wrap clamp and zero frequency
  assign qc_m1 = qc - 32'd1;

  always_comb begin
    sb2_nxt = sb_c;
    if (sb_c.freq == '0) begin
      sb2_nxt.wrap  = WRAP_MAX;
      sb2_nxt.div16 = DIV16_MAX;
      sb2_nxt.err   = 1'b1;
    end else if (qc == '0) begin
      sb2_nxt.wrap = '0;
    end else if (qc_m1 > 32'(WRAP_MAX)) begin
      sb2_nxt.wrap = WRAP_MAX;
    end else begin
      sb2_nxt.wrap = qc_m1[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb2_r  <= '0;
      sb3_r  <= '0;
      sb4_r  <= '0;
      prod_r <= '0;
      rec_r  <= '0;
    end else if (en) begin
      sb2_r  <= sb2_nxt;
      sb3_r  <= sb2_r;
      sb4_r  <= sb3_r;
      prod_r <= 25'(sb2_r.wrap) * 25'(sb2_r.duty);
      rec_r  <= 45'(prod_r[24:3]) * 45'(LEVEL_RECIP);
    end
  end

  assign lvl_q = rec_r[44:28];

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_div16_r <= '0;
      out_wrap_r  <= '0;
      out_level_r <= '0;
      out_err_r   <= 1'b0;
    end else if (en) begin
      out_valid_r <= sb4_r.vld;
      out_div16_r <= sb4_r.div16;
      out_wrap_r  <= sb4_r.wrap;
      out_level_r <= (lvl_q > 17'(WRAP_MAX)) ? WRAP_MAX : lvl_q[15:0];
      out_err_r   <= sb4_r.err;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_div_int       = out_div16_r[11:4];
  assign out_div_frac      = out_div16_r[3:0];
  assign out_wrap_value    = out_wrap_r;
  assign out_compare_level = out_level_r;
  assign out_range_error   = out_err_r;

endmodule

@@ hw/rtl/pdw_div.sv @@
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps

module pdw_div
  import pdw_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] num,
  input  logic [19:0] den,
  output logic [31:0] quo
);

  logic [19:0] rem_r [DIV_STAGES];
  logic [31:0] n_r   [DIV_STAGES];
  logic [19:0] d_r   [DIV_STAGES];

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
    logic [19:0] rem_in;
    logic [31:0] n_in;
    logic [19:0] d_in;
    logic [20:0] t;
    logic        ge;
    logic [20:0] diff;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign n_in   = num;
      assign d_in   = den;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign n_in   = n_r[i-1];
      assign d_in   = d_r[i-1];
    end

    assign t    = {rem_in, n_in[31]};
    assign ge   = t >= {1'b0, d_in};
    assign diff = t - {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? diff[19:0] : t[19:0];
        n_r[i]   <= {n_in[30:0], ge};
        d_r[i]   <= d_in;
      end
    end
  end

  assign quo = n_r[DIV_STAGES-1];

endmodule

@@ hw/rtl/pdw_dly.sv @@
// sideband delay line matching the divider latency
`timescale 1ns / 1ps

module pdw_dly
  import pdw_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  pdw_sb_t din,
  output pdw_sb_t dout
);

  pdw_sb_t line_r [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_STAGES; i++) line_r[i] <= '0;
    end else if (en) begin
      line_r[0] <= din;
      for (int i = 1; i < DIV_STAGES; i++) line_r[i] <= line_r[i-1];
    end
  end

  assign dout = line_r[DIV_STAGES-1];

endmodule

@@ hw/rtl/pdw_checker.sv @@
// port level checks for the pwm divider calculator, bound to the top level
`timescale 1ns / 1ps

module pdw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_ready,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_div_int,
  input logic [15:0] out_wrap_value
);

  // divider is never below one
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_div_int != 8'd0) else $error("divider below one");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("word after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready) else $error("config port not ready");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_wrap_value))
    else $error("stalled word changed");

endmodule

bind pwm_divider_wrap_level_calc pdw_checker u_pdw_checker (
  .clk(clk), .rst_n(rst_n), .cfg_ready(cfg_ready), .out_valid(out_valid),
  .out_stall(out_stall), .out_div_int(out_div_int),
  .out_wrap_value(out_wrap_value)
);
